FILE: rtl/i2w_pkg.sv
// ----------------------------------------------------------------------------
// i2w_pkg
// Shared types, token codes and helper functions for integer_to_word_tokens.
// ----------------------------------------------------------------------------
package i2w_pkg;

  localparam int VALUE_W  = 31;
  localparam int WORD_W   = 5;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int GROUPS   = 4;
  localparam int GRP_TOKS = 5;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [3:0]         digit_t;
  typedef logic [2:0]         gcnt_t;

  localparam word_t TOK_ZERO      = 5'd0;
  localparam word_t TOK_TENS_BASE = 5'd18;
  localparam word_t TOK_HUNDRED   = 5'd28;
  localparam word_t TOK_THOUSAND  = 5'd29;
  localparam word_t TOK_MILLION   = 5'd30;
  localparam word_t TOK_BILLION   = 5'd31;

  typedef struct packed {
    logic [GRP_TOKS-1:0][WORD_W-1:0] tok;
    gcnt_t                           cnt;
  } group_t;

  // Index 0 holds billions, index 3 the units group.
  typedef group_t [GROUPS-1:0] groups_t;

  // Spell one three-digit group, optionally followed by its scale word.
  function automatic group_t spell_group(digit_t h, digit_t t, digit_t u,
                                         word_t scale, logic scaled);
    group_t g;
    gcnt_t  n;
    g.tok = '0;
    n     = '0;
    if (h != 4'd0) begin
      g.tok[n] = {1'b0, h};
      n = n + 3'd1;
      g.tok[n] = TOK_HUNDRED;
      n = n + 3'd1;
    end
    if (t >= 4'd2) begin
      g.tok[n] = TOK_TENS_BASE + {1'b0, t};
      n = n + 3'd1;
      if (u != 4'd0) begin
        g.tok[n] = {1'b0, u};
        n = n + 3'd1;
      end
    end else if (t != 4'd0 || u != 4'd0) begin
      g.tok[n] = (t[0] ? 5'd10 : 5'd0) + {1'b0, u};
      n = n + 3'd1;
    end
    if (scaled && (h != 4'd0 || t != 4'd0 || u != 4'd0)) begin
      g.tok[n] = scale;
      n = n + 3'd1;
    end
    g.cnt = n;
    return g;
  endfunction

  // First set bit of nz at or above position start; returns start if none.
  function automatic logic [1:0] first_from(logic [GROUPS-1:0] nz, logic [1:0] start);
    logic [1:0] r;
    r = start;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (nz[i] && (i >= int'(start))) begin
        r = 2'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/i2w_if.sv
// ----------------------------------------------------------------------------
// i2w channel interfaces
// Valid/ready channels for input values and output word tokens.
// ----------------------------------------------------------------------------
interface i2w_in_if;
  logic                              valid;
  logic                              ready;
  logic [i2w_pkg::VALUE_W-1:0]       value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2w_out_if;
  logic                              valid;
  logic                              ready;
  logic [i2w_pkg::WORD_W-1:0]        word;
  logic                              last;
  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

FILE: rtl/i2w_dd_stage.sv
// ----------------------------------------------------------------------------
// i2w_dd_stage
// One register stage of the binary to BCD converter: STEPS shift-add-3 steps.
// ----------------------------------------------------------------------------
module i2w_dd_stage #(
  parameter int STEPS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2w_pkg::bcd_t         in_bcd,
  input  i2w_pkg::value_t       in_bin,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2w_pkg::bcd_t         out_bcd,
  output i2w_pkg::value_t       out_bin
);

  i2w_pkg::bcd_t   bcd_next;
  i2w_pkg::value_t bin_next;

  always_comb begin
    bcd_next = in_bcd;
    bin_next = in_bin;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < i2w_pkg::DIGITS; d++) begin
        if (bcd_next[d*4 +: 4] >= 4'd5) begin
          bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[i2w_pkg::BCD_W-2:0], bin_next[i2w_pkg::VALUE_W-1]};
      bin_next = {bin_next[i2w_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_bcd <= bcd_next;
      out_bin <= bin_next;
    end
  end

endmodule

FILE: rtl/i2w_tokenize.sv
// ----------------------------------------------------------------------------
// i2w_tokenize
// Register stage that spells the four digit groups into per-group token lists.
// ----------------------------------------------------------------------------
module i2w_tokenize (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2w_pkg::bcd_t         in_bcd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2w_pkg::groups_t      out_groups
);

  i2w_pkg::groups_t groups_next;

  always_comb begin
    groups_next[0] = i2w_pkg::spell_group(4'd0, 4'd0, in_bcd[39:36],
                                          i2w_pkg::TOK_BILLION, 1'b1);
    groups_next[1] = i2w_pkg::spell_group(in_bcd[35:32], in_bcd[31:28], in_bcd[27:24],
                                          i2w_pkg::TOK_MILLION, 1'b1);
    groups_next[2] = i2w_pkg::spell_group(in_bcd[23:20], in_bcd[19:16], in_bcd[15:12],
                                          i2w_pkg::TOK_THOUSAND, 1'b1);
    groups_next[3] = i2w_pkg::spell_group(in_bcd[11:8], in_bcd[7:4], in_bcd[3:0],
                                          i2w_pkg::TOK_ZERO, 1'b0);
    // Zero spells as a single word in the units group.
    if (in_bcd == '0) begin
      groups_next[3].tok    = '0;
      groups_next[3].tok[0] = i2w_pkg::TOK_ZERO;
      groups_next[3].cnt    = 3'd1;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_groups <= groups_next;
    end
  end

endmodule

FILE: rtl/i2w_serial.sv
// ----------------------------------------------------------------------------
// i2w_serial
// Holds one spelled value and walks its groups, one word token per cycle while token.ready is high.
// ----------------------------------------------------------------------------
module i2w_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2w_pkg::groups_t  in_groups,
  i2w_out_if.source         token
);

  logic                              busy;
  i2w_pkg::groups_t                  groups;
  logic [1:0]                        g;
  i2w_pkg::gcnt_t                    p;
  logic [i2w_pkg::GROUPS-1:0]        nz;
  logic [i2w_pkg::GROUPS-1:0]        in_nz;
  logic                              later;
  logic                              at_end;
  logic                              is_last;
  logic                              take;
  i2w_pkg::group_t                   cur;

  always_comb begin
    cur   = groups[g];
    later = 1'b0;
    for (int i = 0; i < i2w_pkg::GROUPS; i++) begin
      nz[i]    = groups[i].cnt != 3'd0;
      in_nz[i] = in_groups[i].cnt != 3'd0;
      if (nz[i] && (i > int'(g))) begin
        later = 1'b1;
      end
    end
  end

  assign at_end      = (p == cur.cnt - 3'd1);
  assign is_last     = at_end && !later;
  assign take        = busy && token.ready;
  assign token.valid = busy;
  assign token.word  = cur.tok[p];
  assign token.last  = is_last;
  // Accept a new item when idle, or while the final token of this one leaves.
  assign in_ready    = !busy || (token.ready && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (take && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      groups <= in_groups;
      g      <= i2w_pkg::first_from(in_nz, 2'd0);
      p      <= '0;
    end else if (take && !is_last) begin
      if (at_end) begin
        g <= i2w_pkg::first_from(nz, g + 2'd1);
        p <= '0;
      end else begin
        p <= p + 3'd1;
      end
    end
  end

  a_pos_in_group: assert property (@(posedge clk) disable iff (rst)
    busy |-> (p < cur.cnt))
    else $error("token position past end of group");

  a_group_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> nz[g])
    else $error("walking an empty group");

  a_stay_busy: assert property (@(posedge clk) disable iff (rst)
    (take && !is_last) |=> busy)
    else $error("item dropped before its last token");

endmodule

FILE: rtl/integer_to_word_tokens.sv
// ----------------------------------------------------------------------------
// integer_to_word_tokens
// Spells a 31-bit unsigned integer as a run of English word tokens.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one value per item (valid/ready). token carries one
//   word code per item with a last flag on the final word of each value.
//   Codes: 0-19 Zero..Nineteen, 20-27 Twenty..Ninety, 28 Hundred,
//   29 Thousand, 30 Million, 31 Billion.
// Structure: four register stages convert binary to ten BCD digits
//   (eight shift-add-3 steps each, seven in the last), one stage spells the
//   four three-digit groups, and a serializer walks the groups.
// Path: a value passes the four conversion stages, the spelling stage and
//   the serializer's group register before its first token is offered.
// Throughput: one token per cycle while token.ready is high; a value has
//   1 to 16 words and holds the serializer until its last token is taken.
//   The next value loads as the last token is taken.
// Reset: rst (synchronous) clears all stage valid bits and the serializer.
// Stall: when token.ready is low the current token holds, the pipeline
//   fills behind it and request.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module integer_to_word_tokens (
  input  logic       clk,
  input  logic       rst,
  i2w_in_if.sink     request,
  i2w_out_if.source  token
);

  localparam int STAGES = 4;

  logic              v   [STAGES+1];
  logic              r   [STAGES+1];
  i2w_pkg::bcd_t     bcd [STAGES+1];
  i2w_pkg::value_t   bin [STAGES+1];

  logic              tk_valid;
  logic              tk_ready;
  i2w_pkg::groups_t  tk_groups;

  // Stage zero feeds from the input channel with an empty BCD accumulator.
  assign v[0]          = request.valid;
  assign request.ready = r[0];
  assign bcd[0]        = '0;
  assign bin[0]        = request.value;

  for (genvar i = 0; i < STAGES; i++) begin : g_dd
    localparam int STEPS = (i == STAGES - 1) ? 7 : 8;
    i2w_dd_stage #(.STEPS(STEPS)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_ready  (r[i]),
      .in_bcd    (bcd[i]),
      .in_bin    (bin[i]),
      .out_valid (v[i+1]),
      .out_ready (r[i+1]),
      .out_bcd   (bcd[i+1]),
      .out_bin   (bin[i+1])
    );
  end

  i2w_tokenize u_tokenize (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v[STAGES]),
    .in_ready   (r[STAGES]),
    .in_bcd     (bcd[STAGES]),
    .out_valid  (tk_valid),
    .out_ready  (tk_ready),
    .out_groups (tk_groups)
  );

  i2w_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tk_valid),
    .in_ready  (tk_ready),
    .in_groups (tk_groups),
    .token     (token)
  );

endmodule

FILE: bench/tb_integer_to_word_tokens.sv
// ----------------------------------------------------------------------------
// tb_integer_to_word_tokens
// Sends integers through the request channel and checks each word token
// against a spelling computed in the bench, under varied idling and stalls.
// ----------------------------------------------------------------------------
module tb_integer_to_word_tokens;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    i2w_pkg::word_t word;
    logic           last;
  } token_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  i2w_in_if  req_ch();
  i2w_out_if tok_ch();

  integer_to_word_tokens dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch.sink),
    .token   (tok_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  token_item_t spelled_q[$];
  int          errors       = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          idle_cycles  = 0;
  bit          hold_recv    = 1'b0;

  // Append the spelling of one group (1..999) to the expected tokens.
  task automatic add_group(int unsigned grp);
    int unsigned h;
    int unsigned rest;
    token_item_t t;
    h = grp / 100;
    rest = grp % 100;
    t.last = 1'b0;
    if (h != 0) begin
      t.word = i2w_pkg::word_t'(h);
      spelled_q.push_back(t);
      t.word = i2w_pkg::TOK_HUNDRED;
      spelled_q.push_back(t);
    end
    if (rest == 0) return;
    if (rest < 20) begin
      t.word = i2w_pkg::word_t'(rest);
      spelled_q.push_back(t);
    end else begin
      t.word = i2w_pkg::TOK_TENS_BASE + i2w_pkg::word_t'(rest / 10);
      spelled_q.push_back(t);
      if (rest % 10 != 0) begin
        t.word = i2w_pkg::word_t'(rest % 10);
        spelled_q.push_back(t);
      end
    end
  endtask

  // Predict the full token run for one value.
  task automatic spell_value(i2w_pkg::value_t v);
    int unsigned n;
    token_item_t t;
    n = v;
    if (n == 0) begin
      t.word = i2w_pkg::TOK_ZERO;
      t.last = 1'b1;
      spelled_q.push_back(t);
      return;
    end
    if (n / 1000000000 != 0) begin
      add_group(n / 1000000000);
      t.word = i2w_pkg::TOK_BILLION; t.last = 1'b0; spelled_q.push_back(t);
    end
    if ((n / 1000000) % 1000 != 0) begin
      add_group((n / 1000000) % 1000);
      t.word = i2w_pkg::TOK_MILLION; t.last = 1'b0; spelled_q.push_back(t);
    end
    if ((n / 1000) % 1000 != 0) begin
      add_group((n / 1000) % 1000);
      t.word = i2w_pkg::TOK_THOUSAND; t.last = 1'b0; spelled_q.push_back(t);
    end
    if (n % 1000 != 0) add_group(n % 1000);
    spelled_q[$].last = 1'b1;
  endtask

  // Offer one value, with random idle cycles ahead of it, and wait for acceptance.
  // Valid stays high after acceptance until the next value or an idle cycle.
  task automatic send_value(i2w_pkg::value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    spell_value(v);
    @(negedge clk);
  endtask

  // Drop the request, hold until every expected token is back, then let the pipe drain.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (spelled_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Build a value with three-digit groups drawn toward the interesting cases.
  function automatic i2w_pkg::value_t shaped_value();
    int unsigned g[4];
    longint unsigned v;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(5))
        0: g[i] = 0;
        1: g[i] = $urandom_range(19);
        2: g[i] = $urandom_range(9) * 100 + $urandom_range(10, 19);
        3: g[i] = $urandom_range(9) * 100 + $urandom_range(2, 9) * 10;
        default: g[i] = $urandom_range(999);
      endcase
    end
    g[0] = g[0] % 3;
    v = longint'(g[0]) * 1000000000 + g[1] * 1000000 + g[2] * 1000 + g[3];
    if (v > 64'h7FFFFFFF) v = 64'h7FFFFFFF;
    return i2w_pkg::value_t'(v);
  endfunction

  task automatic test_directed();
    i2w_pkg::value_t vals[$];
    vals = '{0, 1, 9, 10, 13, 19, 20, 21, 99, 100, 101, 110, 115, 999, 1000,
             1001, 1000000, 1000000000, 2000000000, 1777777777, 1234567891,
             1013014015, 2147483647, 1000000010, 2147483646};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random(int count);
    i2w_pkg::value_t v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) v = i2w_pkg::value_t'($urandom());
      else v = shaped_value();
      send_value(v);
    end
  endtask

  // Stall the receiver for a long stretch while values keep coming.
  task automatic test_backpressure();
    hold_recv = 1'b1;
    fork
      test_random(12);
      begin
        repeat (300) @(negedge clk);
        hold_recv = 1'b0;
      end
    join
    drain();
    // Sender pauses until all tokens are back, then sends once more.
    send_value(i2w_pkg::value_t'(1777777777));
    drain();
  endtask

  // Receiver: randomize ready at the falling edge.
  always @(negedge clk) begin
    if (rst) tok_ch.ready <= 1'b0;
    else tok_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // Checker: compare each accepted token with the oldest expectation.
  always @(posedge clk) begin
    token_item_t exp_tok;
    if (!rst && tok_ch.valid && tok_ch.ready) begin
      if (spelled_q.size() == 0) begin
        $display("%0t unexpected token word=%0d last=%0b", $time, tok_ch.word, tok_ch.last);
        errors++;
      end else begin
        exp_tok = spelled_q.pop_front();
        if (tok_ch.word !== exp_tok.word) begin
          $display("%0t word mismatch expected %0d actual %0d",
                   $time, exp_tok.word, tok_ch.word);
          errors++;
        end
        if (tok_ch.last !== exp_tok.last) begin
          $display("%0t last mismatch expected %0b actual %0b",
                   $time, exp_tok.last, tok_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run after too long with nothing accepted.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    send_idle_pct = 21; recv_idle_pct = 57;
    test_random(100);
    send_idle_pct = 57; recv_idle_pct = 21;
    test_random(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(80);
    test_backpressure();
    drain();

    if (errors == 0 && spelled_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/i2w_pkg.sv
rtl/i2w_if.sv
rtl/i2w_dd_stage.sv
rtl/i2w_tokenize.sv
rtl/i2w_serial.sv
rtl/integer_to_word_tokens.sv
bench/tb_integer_to_word_tokens.sv
